@@ design/rau_pkg.sv @@
`timescale 1ns / 1ps
package rau_pkg;
  localparam int unsigned DW = 32;
  localparam int unsigned CW = $clog2(DW + 1);

  typedef enum logic [2:0] {
    KIND_ADD = 3'd0,
    KIND_SUB = 3'd1,
    KIND_MUL = 3'd2,
    KIND_DIV = 3'd3,
    KIND_RED = 3'd4
  } kind_e;

  // micro-operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE  = 4'd0,
    OP_LOAD  = 4'd1,
    OP_MUL1  = 4'd2,
    OP_MUL2  = 4'd3,
    OP_COMB  = 4'd4,
    OP_MODST = 4'd5,
    OP_MODIT = 4'd6,
    OP_SWAP  = 4'd7,
    OP_DIVST = 4'd8,
    OP_DIVIT = 4'd9,
    OP_DIVEN = 4'd10,
    OP_PASS  = 4'd11
  } op_e;

  typedef struct packed {
    op_e        op;
    logic       second; // second exact division (denominator)
  } cmd_t;

  typedef struct packed {
    logic       den_eq;
    logic       b_zero;   // euclid remainder operand zero
    logic       g_zero;   // both magnitudes zero
    logic       it_done;  // bit iteration finished
  } sts_t;
endpackage

@@ design/rau_datapath.sv @@
`timescale 1ns / 1ps
module rau_datapath
  import rau_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cmd_t          cmd_i,
  input  logic [2:0]    kind_i,
  input  logic [DW-1:0] an_i,
  input  logic [DW-1:0] ad_i,
  input  logic [DW-1:0] bn_i,
  input  logic [DW-1:0] bd_i,
  output sts_t          sts_o,
  output logic [DW-1:0] rn_o,
  output logic [DW-1:0] rd_o,
  output logic          err_o
);
  logic [DW-1:0] an_q, ad_q, bn_q, bd_q, an_d, ad_d, bn_d, bd_d;
  logic [DW-1:0] p0_q, p1_q, p0_d, p1_d;
  logic [DW-1:0] rn_q, rd_q, rn_d, rd_d;
  logic          err_q, err_d;
  logic [2:0]    kind_q, kind_d;
  // euclid / divider registers
  logic [DW-1:0] ga_q, gb_q, ga_d, gb_d;
  logic [DW-1:0] rem_q, rem_d, quo_q, quo_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] mag_a, mag_d, dsrc, dmag;
  logic          dneg;
  logic [DW:0]   trial;
  logic [DW-1:0] shifted, divisor;

  assign mag_a = an_q[DW-1] ? (~an_q + 1'b1) : an_q;
  assign mag_d = ad_q[DW-1] ? (~ad_q + 1'b1) : ad_q;
  // dividend for restoring step: modulo uses ga, division uses an or ad
  always_comb begin
    dsrc = cmd_i.second ? ad_q : an_q;
    dneg = dsrc[DW-1];
    dmag = dneg ? (~dsrc + 1'b1) : dsrc;
  end
  assign divisor = (cmd_i.op == OP_MODIT) ? gb_q : ga_q;
  assign shifted = {rem_q[DW-2:0], quo_q[DW-1]};
  assign trial = {rem_q, quo_q[DW-1]} - {1'b0, divisor};

  always_comb begin
    an_d = an_q; ad_d = ad_q; bn_d = bn_q; bd_d = bd_q;
    p0_d = p0_q; p1_d = p1_q; rn_d = rn_q; rd_d = rd_q;
    err_d = err_q; kind_d = kind_q;
    ga_d = ga_q; gb_d = gb_q; rem_d = rem_q; quo_d = quo_q; cnt_d = cnt_q;
    unique case (cmd_i.op)
      OP_LOAD: begin
        an_d = an_i; ad_d = ad_i; bn_d = bn_i; bd_d = bd_i;
        kind_d = kind_i; err_d = 1'b0;
      end
      // products, plus the cross denominator for add and subtract
      OP_MUL1: begin
        unique case (kind_q)
          KIND_MUL: begin p0_d = an_q * bn_q; p1_d = ad_q * bd_q; end
          KIND_DIV: begin p0_d = an_q * bd_q; p1_d = ad_q * bn_q; end
          default:  begin
            p0_d = an_q * bd_q; p1_d = ad_q * bn_q; rd_d = ad_q * bd_q;
          end
        endcase
      end
      // final combination: products, or the numerators alone when denominators are equal
      OP_COMB: begin
        unique case (kind_q)
          KIND_ADD: if (ad_q == bd_q) begin rn_d = an_q + bn_q; rd_d = ad_q; end
                    else rn_d = p0_q + p1_q;
          KIND_SUB: if (ad_q == bd_q) begin rn_d = an_q - bn_q; rd_d = ad_q; end
                    else rn_d = p0_q - p1_q;
          KIND_MUL: begin rn_d = p0_q; rd_d = p1_q; end
          KIND_DIV: begin rn_d = p0_q; rd_d = p1_q; end
          default:  begin rn_d = an_q; rd_d = ad_q; end
        endcase
      end
      OP_PASS: begin rn_d = an_q; rd_d = ad_q; err_d = 1'b0; end
      // start euclid: ga = |a|, gb = |d|
      OP_MODST: begin
        ga_d = mag_a; gb_d = mag_d;
        err_d = (mag_a == '0) && (mag_d == '0);
        rn_d = an_q; rd_d = ad_q;
      end
      // one bit step of the remainder ga mod gb per cycle: quo shifts ga out
      OP_MODIT: begin
        if (cnt_q == '0) begin
          rem_d = '0; quo_d = ga_q; cnt_d = CW'(DW);
        end else begin
          quo_d = {quo_q[DW-2:0], 1'b0};
          rem_d = trial[DW] ? shifted : trial[DW-1:0];
          cnt_d = cnt_q - 1'b1;
        end
      end
      OP_SWAP: begin ga_d = gb_q; gb_d = rem_q; cnt_d = '0; end
      OP_DIVST: begin
        rem_d = '0; quo_d = dmag; cnt_d = CW'(DW);
      end
      OP_DIVIT: begin
        quo_d = {quo_q[DW-2:0], ~trial[DW]};
        rem_d = trial[DW] ? shifted : trial[DW-1:0];
        cnt_d = cnt_q - 1'b1;
      end
      OP_DIVEN: begin
        if (cmd_i.second) rd_d = dneg ? (~quo_q + 1'b1) : quo_q;
        else rn_d = dneg ? (~quo_q + 1'b1) : quo_q;
        cnt_d = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      err_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      err_q <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    an_q <= an_d; ad_q <= ad_d; bn_q <= bn_d; bd_q <= bd_d;
    p0_q <= p0_d; p1_q <= p1_d; rn_q <= rn_d; rd_q <= rd_d;
    kind_q <= kind_d; ga_q <= ga_d; gb_q <= gb_d;
    rem_q <= rem_d; quo_q <= quo_d;
  end

  assign sts_o.den_eq  = (ad_q == bd_q);
  assign sts_o.b_zero  = (gb_q == '0);
  assign sts_o.g_zero  = err_q;
  assign sts_o.it_done = (cnt_q == CW'(1));
  assign rn_o  = rn_q;
  assign rd_o  = rd_q;
  assign err_o = err_q;
endmodule

@@ design/rau_ctrl.sv @@
`timescale 1ns / 1ps
module rau_ctrl
  import rau_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] kind_i,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  input  sts_t       sts_i,
  output cmd_t       cmd_o
);
  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_ARITH = 10'b0000000010,
    S_COMB  = 10'b0000000100,
    S_RST   = 10'b0000001000,
    S_MODIT = 10'b0000010000,
    S_SWAP  = 10'b0000100000,
    S_DIVST = 10'b0001000000,
    S_DIVIT = 10'b0010000000,
    S_DIVEN = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic   second_q, second_d;
  logic   red_q, red_d;
  logic   first_q, first_d; // first modulo bit step, right after priming in S_RST

  always_comb begin
    state_d = state_q; second_d = second_q; red_d = red_q; first_d = first_q;
    cmd_o.op = OP_NONE; cmd_o.second = second_q;
    in_ready_o = 1'b0; out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          red_d = (kind_i == KIND_RED);
          second_d = 1'b0;
          state_d = S_ARITH;
        end
      end
      S_ARITH: begin
        if (red_q) begin cmd_o.op = OP_MODST; state_d = S_RST; end
        else begin cmd_o.op = OP_MUL1; state_d = S_COMB; end
      end
      S_COMB: begin cmd_o.op = OP_COMB; state_d = S_OUT; end
      S_RST: begin
        if (sts_i.g_zero) state_d = S_OUT;
        else if (sts_i.b_zero) state_d = S_DIVST;
        else begin cmd_o.op = OP_MODIT; first_d = 1'b1; state_d = S_MODIT; end
      end
      S_MODIT: begin
        cmd_o.op = OP_MODIT;
        first_d = 1'b0;
        if (!first_q && sts_i.it_done) state_d = S_SWAP;
      end
      S_SWAP: begin cmd_o.op = OP_SWAP; state_d = S_RST; end
      S_DIVST: begin cmd_o.op = OP_DIVST; state_d = S_DIVIT; end
      S_DIVIT: begin
        cmd_o.op = OP_DIVIT;
        if (sts_i.it_done) state_d = S_DIVEN;
      end
      S_DIVEN: begin
        cmd_o.op = OP_DIVEN;
        if (second_q) state_d = S_OUT;
        else begin second_d = 1'b1; state_d = S_DIVST; end
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; second_q <= 1'b0; red_q <= 1'b0; first_q <= 1'b0;
    end else begin
      state_q <= state_d; second_q <= second_d; red_q <= red_d; first_q <= first_d;
    end
  end

`ifndef ASSERT_OFF
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("accept while result pending");
`endif
endmodule

@@ design/rational_arith_unit.sv @@
`timescale 1ns / 1ps
// Rational ALU: one request carries two fractions and an operation; one result
// comes back. Add, subtract, multiply and divide load the operands, then form
// the products, then combine them, and then present the result.
// Reduce runs Euclid on the magnitudes with a bit-serial remainder unit, then
// two bit-serial exact divisions by the gcd; with both parts zero the Euclid
// start goes straight to the result, with the error flag set. One request is
// in flight at a time; the next can be accepted in the cycle after the result
// has been taken.
module rational_arith_unit
  import rau_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata, // kind, first_num, first_den, second_num, second_den
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata, // result_num, result_den
  output logic         m_axis_tuser  // zero_gcd_error
);
  cmd_t cmd;
  sts_t sts;

  rau_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .kind_i     (s_axis_tdata[2:0]),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rau_datapath u_dp (
    .clk_i, .rst_ni,
    .cmd_i  (cmd),
    .kind_i (s_axis_tdata[2:0]),
    .an_i   (s_axis_tdata[34:3]),
    .ad_i   (s_axis_tdata[66:35]),
    .bn_i   (s_axis_tdata[98:67]),
    .bd_i   (s_axis_tdata[130:99]),
    .sts_o  (sts),
    .rn_o   (m_axis_tdata[31:0]),
    .rd_o   (m_axis_tdata[63:32]),
    .err_o  (m_axis_tuser)
  );
endmodule

@@ dv/tb_rational_arith_unit.sv @@
`timescale 1ns / 1ps
module tb_rational_arith_unit;
  import rau_pkg::*;

  typedef struct packed {
    logic [31:0] num;
    logic [31:0] den;
    logic        err;
  } frac_res_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;
  logic         m_axis_tuser;

  frac_res_t   expected_q[$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned requests_sent = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned stall_mode = 0;
  bit          timed_out = 1'b0;

  localparam int unsigned IDLE_LIMIT = 20000;

  always #2 clk_i = ~clk_i;

  rational_arith_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // euclid on unsigned magnitudes
  function automatic logic [31:0] gcd_of(logic [31:0] a, logic [31:0] b);
    logic [31:0] r;
    while (b != 0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  function automatic logic [31:0] mag_of(logic [31:0] w);
    return w[31] ? (32'd0 - w) : w;
  endfunction

  // exact signed division by a positive divisor
  function automatic logic [31:0] sdiv_exact(logic [31:0] w, logic [31:0] d);
    logic [31:0] q;
    q = mag_of(w) / d;
    return w[31] ? (32'd0 - q) : q;
  endfunction

  function automatic frac_res_t compute_fraction(logic [2:0] kind, logic [31:0] an,
                                                 logic [31:0] ad, logic [31:0] bn,
                                                 logic [31:0] bd);
    frac_res_t r;
    logic [31:0] g;
    r.num = an;
    r.den = ad;
    r.err = 1'b0;
    case (kind)
      KIND_ADD, KIND_SUB: begin
        if (ad == bd) begin
          r.den = ad;
          r.num = (kind == KIND_ADD) ? an + bn : an - bn;
        end else begin
          r.den = ad * bd;
          r.num = (kind == KIND_ADD) ? an * bd + ad * bn : an * bd - ad * bn;
        end
      end
      KIND_MUL: begin
        r.den = ad * bd;
        r.num = an * bn;
      end
      KIND_DIV: begin
        r.num = an * bd;
        r.den = ad * bn;
      end
      KIND_RED: begin
        g = gcd_of(mag_of(an), mag_of(ad));
        if (g == 0) begin
          r.err = 1'b1;
        end else begin
          r.num = sdiv_exact(an, g);
          r.den = sdiv_exact(ad, g);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // send one request, with bursts and gaps on the sender side
  task automatic send_fraction(logic [2:0] kind, logic [31:0] an, logic [31:0] ad,
                               logic [31:0] bn, logic [31:0] bd);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'd0, bd, bn, ad, an, kind};
    expected_q.push_back(compute_fraction(kind, an, ad, bn, bd));
    do @(posedge clk_i); while (!s_axis_tready);
    requests_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0 && !timed_out) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'd0;
      3: return $urandom_range(0, 40) - 20;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_extremes();
    logic [31:0] vals[6] = '{32'h8000_0000, 32'h7fff_ffff, 32'd0, 32'hffff_ffff, 32'd1,
                             32'hAAAA_5555};
    for (int k = 0; k < 5; k++) begin
      send_fraction(k[2:0], vals[k], vals[k+1], vals[5-k], vals[(k+3)%6]);
    end
    // shared denominators on add and subtract
    send_fraction(KIND_ADD, 32'd3, 32'd7, 32'd5, 32'd7);
    send_fraction(KIND_SUB, 32'h8000_0000, 32'hffff_ffff, 32'd1, 32'hffff_ffff);
    // divide by a zero numerator
    send_fraction(KIND_DIV, 32'd5, 32'd3, 32'd0, 32'd9);
    // reduce: both zero, most negative, negative denominator, one part zero
    send_fraction(KIND_RED, 32'd0, 32'd0, 32'd1, 32'd1);
    send_fraction(KIND_RED, 32'h8000_0000, 32'd4, 32'd0, 32'd0);
    send_fraction(KIND_RED, 32'd12, 32'h8000_0000, 32'd0, 32'd0);
    send_fraction(KIND_RED, 32'd18, -32'sd24, 32'd0, 32'd0);
    send_fraction(KIND_RED, 32'd0, 32'd15, 32'd0, 32'd0);
    send_fraction(KIND_RED, 32'hffff_ffff, 32'hffff_ffff, 32'd0, 32'd0);
    // unused kinds pass through
    for (int k = 5; k < 8; k++) send_fraction(k[2:0], 32'h1234_5678, 32'hfedc_ba98,
                                                 32'hffff_ffff, 32'hffff_ffff);
  endtask

  task automatic test_random_ops(int unsigned count);
    logic [2:0]  kind;
    logic [31:0] an, ad, bn, bd;
    for (int unsigned i = 0; i < count && !timed_out; i++) begin
      kind = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                          : 3'($urandom_range(0, 4));
      an = rand_word();
      ad = rand_word();
      bn = rand_word();
      bd = ($urandom_range(0, 3) == 0) ? ad : rand_word();
      send_fraction(kind, an, ad, bn, bd);
      if (i == count / 2) drain_results();
    end
  endtask

  // receiver stall pattern: one of three modes, picked at random
  always @(posedge clk_i) begin
    if (results_seen % 50 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      default: m_axis_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // result checker
  always @(posedge clk_i) begin
    frac_res_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h %b", m_axis_tdata, m_axis_tuser);
      end else begin
        exp_r = expected_q.pop_front();
        if (exp_r.num !== m_axis_tdata[31:0] || exp_r.den !== m_axis_tdata[63:32] ||
            exp_r.err !== m_axis_tuser) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %h/%h err %b, got %h/%h err %b", exp_r.num, exp_r.den,
                     exp_r.err, m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser);
        end
      end
    end
  end

  // watchdog on accepted traffic
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("timeout with %0d results outstanding", expected_q.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    drain_results();
    test_random_ops(850);
    drain_results();
    repeat (400) @(posedge clk_i);
    $display("sent %0d requests over all kinds incl. reduce corner cases, checked %0d results",
             requests_sent, results_seen);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d missing", mismatches, expected_q.size());
      $display("status: fail");
    end
    $finish;
  end
endmodule

@@ sim.f @@
design/rau_pkg.sv
design/rau_datapath.sv
design/rau_ctrl.sv
design/rational_arith_unit.sv
dv/tb_rational_arith_unit.sv
